// File: hdl/mvdp_pkg.sv
// Package for the meshlet vertex deduplicating packer.
// Holds widths, register indexes and the controller/datapath command and status types.
// No dependencies.
package mvdp_pkg;

  // Vertex store geometry.
  localparam int VertexSlots = 64;
  localparam int SlotW       = $clog2(VertexSlots);
  localparam int CountW      = SlotW + 1;

  // Field widths.
  localparam int VertexW  = 32;
  localparam int LocalW   = 10;
  localparam int TriW     = 10;
  localparam int MaxVertW = 7;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMaxVertices   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPrimitives = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic search_step;
    logic append_step;
    logic emit;
  } mvdp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic room;
    logic search_done;
    logic fits;
    logic append_last;
  } mvdp_status_t;

endpackage

// File: hdl/mvdp_ctrl.sv
// Controller state machine of the meshlet vertex deduplicating packer.
// Depends on mvdp_pkg for the command and status types.
module mvdp_ctrl
  import mvdp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  mvdp_status_t status_i,
  output mvdp_cmd_t    cmd_o,
  output logic         busy_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSearch = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StAppend = 3'd3;
  localparam logic [2:0] StFinish = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSearch;
        end
      end
      StSearch: begin
        // A full meshlet rejects the triangle without a search.
        if (!status_i.room) begin
          state_d = StFinish;
        end else if (status_i.search_done) begin
          state_d = StDecide;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      StDecide: begin
        state_d = status_i.fits ? StAppend : StFinish;
      end
      StAppend: begin
        cmd_o.append_step = 1'b1;
        if (status_i.append_last) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        cmd_o.emit = 1'b1;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

// File: hdl/mvdp_datapath.sv
// Datapath of the meshlet vertex deduplicating packer: configuration registers,
// vertex store memory, search compare, append logic and result registers.
// Depends on mvdp_pkg.
module mvdp_datapath
  import mvdp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mvdp_cmd_t           cmd_i,
  output mvdp_status_t        status_o,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                cfg_ready_o,
  input  logic                new_meshlet_i,
  input  logic [VertexW-1:0]  vertex_a_i,
  input  logic [VertexW-1:0]  vertex_b_i,
  input  logic [VertexW-1:0]  vertex_c_i,
  output logic                done_o,
  output logic                accepted_o,
  output logic [LocalW-1:0]   local_a_o,
  output logic [LocalW-1:0]   local_b_o,
  output logic [LocalW-1:0]   local_c_o,
  output logic [2:0]          appended_mask_o,
  output logic [MaxVertW-1:0] vertex_total_o,
  output logic [TriW-1:0]     triangle_total_o,
  output logic                meshlet_full_o
);

  logic [MaxVertW-1:0] max_vert_q;
  logic [TriW-1:0]     max_prim_q;
  logic [CountW-1:0]   vcount_q;
  logic [TriW-1:0]     tcount_q;
  logic [CountW-1:0]   vlimit;

  logic [2:0][VertexW-1:0] corner_q;
  logic [2:0][CountW-1:0]  slot_q;
  logic [2:0]              hit_q;
  logic [2:0]              mask_q;
  logic                    ok_q;

  logic [CountW-1:0] rd_idx_q;
  logic [CountW-1:0] cmp_idx_q;
  logic              cmp_vld_q;
  logic [VertexW-1:0] rdata_q;
  logic              issue;

  logic [1:0]        ap_idx_q;
  logic              wr_en;
  logic [1:0]        fresh;
  logic [CountW:0]   vsum;

  logic [VertexW-1:0] mem_q [VertexSlots];

  logic done_q;

  // Configuration is always taken; the user must send it only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  // The limit in force is the smaller of the register and the store depth.
  assign vlimit = (max_vert_q >= MaxVertW'(VertexSlots)) ? CountW'(VertexSlots)
                                                          : CountW'(max_vert_q);

  // Count of corners that found no match, and the vertex count they would give.
  assign fresh = {1'b0, ~hit_q[0]} + {1'b0, ~hit_q[1]} + {1'b0, ~hit_q[2]};
  assign vsum  = {1'b0, vcount_q} + (CountW+1)'(fresh);

  assign issue = cmd_i.search_step && (rd_idx_q < vcount_q);
  assign wr_en = cmd_i.append_step && !hit_q[ap_idx_q];

  // Status to the controller.
  assign status_o.room        = (vcount_q < vlimit) && (tcount_q < max_prim_q);
  assign status_o.search_done = (rd_idx_q == vcount_q) && !cmp_vld_q;
  assign status_o.fits        = (vsum <= {1'b0, vlimit});
  assign status_o.append_last = (ap_idx_q == 2'd2);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vert_q <= MaxVertW'(64);
      max_prim_q <= TriW'(126);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgMaxVertices:   max_vert_q <= cfg_data_i[MaxVertW-1:0];
        CfgMaxPrimitives: max_prim_q <= cfg_data_i[TriW-1:0];
        default: ;
      endcase
    end
  end

  // Meshlet counters and search/append control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q  <= '0;
      tcount_q  <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      ap_idx_q  <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.load) begin
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
        ap_idx_q  <= '0;
        if (new_meshlet_i) begin
          vcount_q <= '0;
          tcount_q <= '0;
        end
      end else begin
        cmp_vld_q <= issue;
        if (issue) begin
          rd_idx_q <= rd_idx_q + CountW'(1);
        end
        if (cmd_i.append_step) begin
          ap_idx_q <= ap_idx_q + 2'd1;
          if (wr_en) begin
            vcount_q <= vcount_q + CountW'(1);
          end
          // The triangle is committed with the last append step.
          if (ap_idx_q == 2'd2) begin
            tcount_q <= tcount_q + TriW'(1);
          end
        end
      end
    end
  end

  // Vertex store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[vcount_q[SlotW-1:0]] <= corner_q[ap_idx_q];
    end
    if (issue) begin
      rdata_q   <= mem_q[rd_idx_q[SlotW-1:0]];
      cmp_idx_q <= rd_idx_q;
    end
  end

  // Per-triangle working registers: corners, hits, slots, append mask and accept flag.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      corner_q[0] <= vertex_a_i;
      corner_q[1] <= vertex_b_i;
      corner_q[2] <= vertex_c_i;
      hit_q       <= '0;
      mask_q      <= '0;
      ok_q        <= 1'b0;
      slot_q      <= '0;
    end else begin
      // Entries are compared in ascending order, so the highest match wins.
      if (cmp_vld_q) begin
        for (int j = 0; j < 3; j++) begin
          if (rdata_q == corner_q[j]) begin
            hit_q[j]  <= 1'b1;
            slot_q[j] <= cmp_idx_q;
          end
        end
      end
      if (wr_en) begin
        slot_q[ap_idx_q] <= vcount_q;
        mask_q[ap_idx_q] <= 1'b1;
      end
      if (cmd_i.append_step && (ap_idx_q == 2'd2)) begin
        ok_q <= 1'b1;
      end
    end
  end

  // Result registers, loaded once per triangle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      accepted_o       <= ok_q;
      local_a_o        <= ok_q ? LocalW'(slot_q[0]) : '0;
      local_b_o        <= ok_q ? LocalW'(slot_q[1]) : '0;
      local_c_o        <= ok_q ? LocalW'(slot_q[2]) : '0;
      appended_mask_o  <= ok_q ? mask_q : 3'd0;
      vertex_total_o   <= MaxVertW'(vcount_q);
      triangle_total_o <= tcount_q;
      meshlet_full_o   <= (vcount_q >= vlimit) || (tcount_q >= max_prim_q);
    end
  end

  assign done_o = done_q;

endmodule

// File: hdl/meshlet_vertex_dedup_packer.sv
// Top level of the meshlet vertex deduplicating packer.
// Joins mvdp_ctrl and mvdp_datapath; depends on mvdp_pkg.
//
//   Channel   Handshake                     Word
//   --------  ----------------------------  ---------------------------------------
//   triangle  start_i, busy_o               new_meshlet_i, vertex_a/b/c_i
//   result    done_o (one-cycle strobe)     accepted_o, local_a/b/c_o, appended_mask_o,
//                                           vertex_total_o, triangle_total_o,
//                                           meshlet_full_o
//   config    cfg_valid_i, cfg_ready_o      cfg_index_i, cfg_data_i
//
// A word is taken when start_i is high and busy_o is low. The vertex store is read
// through one registered port, one entry a cycle. A triangle rejected on a full
// meshlet skips the search, and one whose new corners do not fit skips the appends;
// both still get their strobe. Appends step through the three corners in turn on the
// single write port, writing only those that found no match. busy_o drops with the
// strobe, so the next word can be taken at the edge that ends it. Reset clears the
// counts and restores the limits to 64 and 126; the store needs no clearing. The
// receiver cannot stall: the strobe is not held, but the result words stay until
// the next strobe.
module meshlet_vertex_dedup_packer
  import mvdp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                new_meshlet_i,
  input  logic [VertexW-1:0]  vertex_a_i,
  input  logic [VertexW-1:0]  vertex_b_i,
  input  logic [VertexW-1:0]  vertex_c_i,
  output logic                done_o,
  output logic                accepted_o,
  output logic [LocalW-1:0]   local_a_o,
  output logic [LocalW-1:0]   local_b_o,
  output logic [LocalW-1:0]   local_c_o,
  output logic [2:0]          appended_mask_o,
  output logic [MaxVertW-1:0] vertex_total_o,
  output logic [TriW-1:0]     triangle_total_o,
  output logic                meshlet_full_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  mvdp_cmd_t    cmd;
  mvdp_status_t status;

  // Sequencer.
  mvdp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Store, compare and result datapath.
  mvdp_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cfg_ready_o      (cfg_ready_o),
    .new_meshlet_i    (new_meshlet_i),
    .vertex_a_i       (vertex_a_i),
    .vertex_b_i       (vertex_b_i),
    .vertex_c_i       (vertex_c_i),
    .done_o           (done_o),
    .accepted_o       (accepted_o),
    .local_a_o        (local_a_o),
    .local_b_o        (local_b_o),
    .local_c_o        (local_c_o),
    .appended_mask_o  (appended_mask_o),
    .vertex_total_o   (vertex_total_o),
    .triangle_total_o (triangle_total_o),
    .meshlet_full_o   (meshlet_full_o)
  );

endmodule
